@@ hw/rtl/tsb_pkg.sv @@
`timescale 1ns / 1ps
// tsb_pkg: shared types and constants for the tilt-shift blur/blend block.
// Used by tsb_div and tilt_shift_blur_blend_top; no dependencies.
package tsb_pkg;

  localparam int DIV_W = 32;
  localparam int DVS_W = 13;

  localparam logic [2:0] CFG_IMAGE_WIDTH  = 3'd0;
  localparam logic [2:0] CFG_IMAGE_HEIGHT = 3'd1;
  localparam logic [2:0] CFG_BAND_TOP     = 3'd2;
  localparam logic [2:0] CFG_BAND_BOTTOM  = 3'd3;
  localparam logic [2:0] CFG_DECAY        = 3'd4;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

@@ hw/rtl/tsb_div.sv @@
`timescale 1ns / 1ps
// tsb_div: restoring unsigned divider, one quotient bit per cycle.
// Depends on tsb_pkg.
module tsb_div (
  input  logic              clk,
  input  logic              rst_n,
  input  tsb_pkg::div_req_t req,
  output tsb_pkg::div_rsp_t rsp
);

  localparam int CNT_W = $clog2(tsb_pkg::DIV_W + 1);

  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic                      busy_r, busy_nxt;
  logic                      done_r, done_nxt;
  logic [tsb_pkg::DIV_W-1:0] quo_r, quo_nxt;
  logic [tsb_pkg::DVS_W-1:0] rem_r, rem_nxt;
  logic [tsb_pkg::DVS_W-1:0] dvs_r, dvs_nxt;

  always_comb begin
    logic [tsb_pkg::DVS_W:0] rem_sh;
    logic                    qbit;
    rem_sh   = {rem_r, quo_r[tsb_pkg::DIV_W-1]};
    qbit     = (rem_sh >= {1'b0, dvs_r});
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      cnt_nxt  = CNT_W'(tsb_pkg::DIV_W);
      busy_nxt = 1'b1;
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt = qbit ? tsb_pkg::DVS_W'(rem_sh - {1'b0, dvs_r}) : rem_sh[tsb_pkg::DVS_W-1:0];
      quo_nxt = {quo_r[tsb_pkg::DIV_W-2:0], qbit};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

@@ hw/rtl/tilt_shift_blur_blend_top.sv @@
`timescale 1ns / 1ps
// tilt_shift_blur_blend_top: 3x3 box blur blended with the sharp pixel by a per-row
// tanh weight. Depends on tsb_pkg and tsb_div.
//
//  channel | ports                                   | payload
//  --------+-----------------------------------------+---------------------------------
//  in      | in_tvalid in_tready in_tdata in_tuser   | tdata: blue,green,red; tuser: drain
//  out     | out_tvalid out_tready out_tdata ...     | tdata: blue,green,red; tlast/tuser
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data  | register write
//
// A request that makes no result passes through accept and line read only. Each
// result adds the blur and blend states after the line-memory read. Column 1 of each
// row adds up to two runs of the serial divider that indexes the tanh table. The
// output register holds a result while the next request is taken. Line memories
// need no clearing; ready follows reset.
module tilt_shift_blur_blend_top #(
  parameter int MAX_WIDTH    = 2048,
  parameter int MAX_HEIGHT   = 4096,
  parameter int TANH_ENTRIES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // blue_in, green_in, red_in
  input  logic        in_tuser,   // action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // blue_out, green_out, red_out
  output logic        out_tlast,  // last_in_row
  output logic        out_tuser,  // last_in_frame
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [12:0] cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int IW = $clog2(TANH_ENTRIES);
  localparam longint unsigned Q30 = 64'd1073741824;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_RD   = 4'd1;
  localparam logic [3:0] ST_WNUM = 4'd2;
  localparam logic [3:0] ST_WDIV = 4'd3;
  localparam logic [3:0] ST_WEND = 4'd4;
  localparam logic [3:0] ST_BLUR = 4'd5;
  localparam logic [3:0] ST_BLND = 4'd6;

  // shift-subtract division, used only while building the constant table
  function automatic longint unsigned udiv64(longint unsigned n_in, longint unsigned d_in);
    longint unsigned q, r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n_in[b]};
      if (r >= d_in) begin
        r    = r - d_in;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic longint unsigned exp_neg_q30(longint unsigned f);
    longint          sum;
    longint unsigned term;
    sum  = longint'(Q30);
    term = Q30;
    for (int i = 1; i <= 20; i++) begin
      term = udiv64((term * f) >> 30, 64'(i));
      if ((i & 1) == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    if (sum > longint'(Q30)) sum = longint'(Q30);
    return longint'(sum);
  endfunction

  function automatic logic [TANH_ENTRIES*16-1:0] build_tanh();
    logic [TANH_ENTRIES*16-1:0] tab;
    longint unsigned e1, t, a, n, rm, v;
    longint          p, e;
    tab = '0;
    e1  = exp_neg_q30(Q30);
    for (int k = 0; k < TANH_ENTRIES; k++) begin
      p  = 16 * longint'(k) - 8 * longint'(TANH_ENTRIES);
      a  = (p < 0) ? -p : p;
      n  = udiv64(a, 64'(TANH_ENTRIES));
      rm = a - n * 64'(TANH_ENTRIES);
      t  = exp_neg_q30(udiv64(rm << 30, 64'(TANH_ENTRIES)));
      for (longint unsigned j = 0; j < n; j++) t = (t * e1) >> 30;
      v = udiv64((Q30 - t) * 65536 + (Q30 + t), 2 * (Q30 + t));
      if (v > 32767) v = 32767;
      e = (p < 0) ? -longint'(v) : longint'(v);
      tab[k*16 +: 16] = e[15:0];
    end
    return tab;
  endfunction

  localparam logic [TANH_ENTRIES*16-1:0] TANH_TAB = build_tanh();

  // configuration
  logic [11:0] width_r, top_r, bot_r;
  logic [12:0] height_r;
  logic [6:0]  decay_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 12'd640;
      height_r <= 13'd480;
      top_r    <= '0;
      bot_r    <= '0;
      decay_r  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        tsb_pkg::CFG_IMAGE_WIDTH:  width_r  <= cfg_data[11:0];
        tsb_pkg::CFG_IMAGE_HEIGHT: height_r <= cfg_data;
        tsb_pkg::CFG_BAND_TOP:     top_r    <= cfg_data[11:0];
        tsb_pkg::CFG_BAND_BOTTOM:  bot_r    <= cfg_data[11:0];
        tsb_pkg::CFG_DECAY:        decay_r  <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  logic [CW:0] w_eff;
  logic [RW:0] h_eff;
  always_comb begin
    if (width_r < 12'd3) w_eff = (CW+1)'(3);
    else if (32'(width_r) > 32'(MAX_WIDTH)) w_eff = (CW+1)'(MAX_WIDTH);
    else w_eff = (CW+1)'(width_r);
    if (height_r < 13'd3) h_eff = (RW+1)'(3);
    else if (32'(height_r) > 32'(MAX_HEIGHT)) h_eff = (RW+1)'(MAX_HEIGHT);
    else h_eff = (RW+1)'(height_r);
  end

  // state
  logic [3:0]    state_r, state_nxt;
  logic [CW-1:0] col_r, col_nxt, drn_r, drn_nxt, c_r, c_nxt;
  logic [RW-1:0] row_r, row_nxt, wrow_r, wrow_nxt;
  logic          await_r, await_nxt;
  logic          act_r, act_nxt;
  logic [23:0]   pix_r, pix_nxt;
  logic          fend_r, fend_nxt, second_r, second_nxt, eidx_r, eidx_nxt;
  logic          wsel_r, wsel_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic signed [15:0] ttop_r, ttop_nxt;
  logic signed [16:0] weight_r, weight_nxt;
  logic [23:0]   win_r [9];
  logic [23:0]   win_nxt [9];
  logic [7:0]    blur_r [3];
  logic [7:0]    blur_nxt [3];
  logic [7:0]    sharp_r [3];
  logic [7:0]    sharp_nxt [3];
  logic          lr_r, lr_nxt, lf_r, lf_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [23:0]   out_data_r, out_data_nxt;
  logic          out_last_r, out_last_nxt, out_user_r, out_user_nxt;

  // line memories
  logic [23:0]   above_mem [MAX_WIDTH];
  logic [23:0]   mid_mem [MAX_WIDTH];
  logic [23:0]   above_q, mid_q;
  logic          rd_en, wr_en;
  logic [CW-1:0] rd_addr;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      above_q <= above_mem[rd_addr];
      mid_q   <= mid_mem[rd_addr];
    end
    if (wr_en) begin
      above_mem[c_r] <= mid_q;
      mid_mem[c_r]   <= pix_r;
    end
  end

  tsb_pkg::div_req_t div_req;
  tsb_pkg::div_rsp_t div_rsp;

  tsb_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  logic in_acc;
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign rd_addr   = in_tuser ? drn_r : col_r;
  assign rd_en     = in_acc;

  always_comb begin
    logic [23:0]        top_px, mid_px, bot_px;
    logic               push;
    logic signed [15:0] diff;
    logic [6:0]         d_eff;
    logic signed [31:0] num;
    logic [1:0]         l_col, m_col, r_col;
    logic [11:0]        sum;
    logic [24:0]        recip;
    logic signed [9:0]  dlt;
    logic signed [28:0] v;
    logic [7:0]         res [3];
    logic signed [15:0] tval;

    state_nxt  = state_r;
    col_nxt    = col_r;
    drn_nxt    = drn_r;
    row_nxt    = row_r;
    await_nxt  = await_r;
    c_nxt      = c_r;
    wrow_nxt   = wrow_r;
    act_nxt    = act_r;
    pix_nxt    = pix_r;
    fend_nxt   = fend_r;
    second_nxt = second_r;
    eidx_nxt   = eidx_r;
    wsel_nxt   = wsel_r;
    idx_nxt    = idx_r;
    ttop_nxt   = ttop_r;
    weight_nxt = weight_r;
    win_nxt    = win_r;
    blur_nxt   = blur_r;
    sharp_nxt  = sharp_r;
    lr_nxt     = lr_r;
    lf_nxt     = lf_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    out_user_nxt  = out_user_r;
    wr_en      = 1'b0;
    div_req    = '0;
    top_px     = '0;
    mid_px     = '0;
    bot_px     = '0;
    push       = 1'b0;
    d_eff      = (decay_r == 7'd0) ? 7'd1 : decay_r;
    diff       = wsel_r ? (16'(wrow_r) - 16'(bot_r)) : (16'(wrow_r) - 16'(top_r));
    num        = 32'(diff) * 32'(TANH_ENTRIES) + 32'(d_eff) * 32'(4 * TANH_ENTRIES);
    l_col      = '0;
    m_col      = '0;
    r_col      = '0;
    sum        = '0;
    recip      = '0;
    dlt        = '0;
    v          = '0;
    res        = '{default: '0};
    tval       = $signed(TANH_TAB[idx_r*16 +: 16]);

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          act_nxt = in_tuser;
          pix_nxt = in_tdata;
          c_nxt   = in_tuser ? drn_r : col_r;
          if (in_tuser == await_r) state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        state_nxt = ST_IDLE;
        if (act_r) begin
          push     = 1'b1;
          top_px   = above_q;
          mid_px   = mid_q;
          bot_px   = above_q;
          fend_nxt = 1'b1;
          wrow_nxt = row_r;
          if ((CW+1)'(c_r) + 1'b1 >= w_eff) begin
            await_nxt = 1'b0;
            row_nxt   = '0;
            drn_nxt   = '0;
            col_nxt   = '0;
          end else begin
            drn_nxt = c_r + 1'b1;
          end
        end else begin
          wr_en    = 1'b1;
          push     = (row_r != '0);
          top_px   = (row_r == RW'(1)) ? pix_r : above_q;
          mid_px   = mid_q;
          bot_px   = pix_r;
          fend_nxt = 1'b0;
          wrow_nxt = row_r - 1'b1;
          if ((CW+1)'(c_r) + 1'b1 >= w_eff) begin
            col_nxt = '0;
            if ((RW+1)'(row_r) + 1'b1 >= h_eff) begin
              await_nxt = 1'b1;
              drn_nxt   = '0;
            end else begin
              row_nxt = row_r + 1'b1;
            end
          end else begin
            col_nxt = c_r + 1'b1;
          end
        end
        if (push) begin
          for (int i = 0; i < 6; i++) win_nxt[i] = win_r[i+3];
          win_nxt[6] = top_px;
          win_nxt[7] = mid_px;
          win_nxt[8] = bot_px;
          if (c_r != '0) begin
            second_nxt = ((CW+1)'(c_r) + 1'b1 >= w_eff);
            eidx_nxt   = 1'b0;
            wsel_nxt   = 1'b0;
            state_nxt  = (c_r == CW'(1)) ? ST_WNUM : ST_BLUR;
          end
        end
      end
      ST_WNUM: begin
        if (num > 0) begin
          div_req.start    = 1'b1;
          div_req.dividend = 32'(num <<< 1) + 32'(d_eff) * 32'd8;
          div_req.divisor  = tsb_pkg::DVS_W'(32'(d_eff) * 32'd16);
          state_nxt        = ST_WDIV;
        end else begin
          idx_nxt   = '0;
          state_nxt = ST_WEND;
        end
      end
      ST_WDIV: begin
        if (div_rsp.done) begin
          if (div_rsp.quotient > 32'(TANH_ENTRIES - 1)) idx_nxt = IW'(TANH_ENTRIES - 1);
          else idx_nxt = div_rsp.quotient[IW-1:0];
          state_nxt = ST_WEND;
        end
      end
      ST_WEND: begin
        if (!wsel_r) begin
          ttop_nxt  = tval;
          wsel_nxt  = 1'b1;
          state_nxt = ST_WNUM;
        end else begin
          weight_nxt = 17'(ttop_r) - 17'(tval);
          state_nxt  = ST_BLUR;
        end
      end
      ST_BLUR: begin
        if (!eidx_r) begin
          l_col  = (c_r == CW'(1)) ? 2'd2 : 2'd0;
          m_col  = 2'd1;
          r_col  = 2'd2;
          lr_nxt = 1'b0;
          lf_nxt = 1'b0;
        end else begin
          l_col  = 2'd1;
          m_col  = 2'd2;
          r_col  = 2'd1;
          lr_nxt = 1'b1;
          lf_nxt = fend_r;
        end
        for (int ch = 0; ch < 3; ch++) begin
          sum = '0;
          for (int i = 0; i < 3; i++) begin
            sum = sum + 12'(win_r[l_col*3+i][ch*8 +: 8]) + 12'(win_r[m_col*3+i][ch*8 +: 8])
                + 12'(win_r[r_col*3+i][ch*8 +: 8]);
          end
          recip         = 25'(sum + 12'd4) * 25'd7282;
          blur_nxt[ch]  = recip[23:16];
          sharp_nxt[ch] = win_r[m_col*3+1][ch*8 +: 8];
        end
        state_nxt = ST_BLND;
      end
      ST_BLND: begin
        if (!out_valid_r || out_tready) begin
          for (int ch = 0; ch < 3; ch++) begin
            dlt = 10'(sharp_r[ch]) - 10'(blur_r[ch]);
            v   = 29'(weight_r) * 29'(dlt) + {5'd0, blur_r[ch], 16'd0} + 29'sd32768;
            if (v < 0) res[ch] = 8'd0;
            else if (v[28:16] > 13'd255) res[ch] = 8'd255;
            else res[ch] = v[23:16];
          end
          out_valid_nxt = 1'b1;
          out_data_nxt  = {res[2], res[1], res[0]};
          out_last_nxt  = lr_r;
          out_user_nxt  = lf_r;
          if (!eidx_r && second_r) begin
            eidx_nxt  = 1'b1;
            state_nxt = ST_BLUR;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      col_r       <= '0;
      drn_r       <= '0;
      row_r       <= '0;
      await_r     <= 1'b0;
      weight_r    <= '0;
      out_valid_r <= 1'b0;
      win_r       <= '{default: '0};
    end else begin
      state_r     <= state_nxt;
      col_r       <= col_nxt;
      drn_r       <= drn_nxt;
      row_r       <= row_nxt;
      await_r     <= await_nxt;
      weight_r    <= weight_nxt;
      out_valid_r <= out_valid_nxt;
      win_r       <= win_nxt;
    end
    c_r        <= c_nxt;
    wrow_r     <= wrow_nxt;
    act_r      <= act_nxt;
    pix_r      <= pix_nxt;
    fend_r     <= fend_nxt;
    second_r   <= second_nxt;
    eidx_r     <= eidx_nxt;
    wsel_r     <= wsel_nxt;
    idx_r      <= idx_nxt;
    ttop_r     <= ttop_nxt;
    blur_r     <= blur_nxt;
    sharp_r    <= sharp_nxt;
    lr_r       <= lr_nxt;
    lf_r       <= lf_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
    out_user_r <= out_user_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_user_r;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> (out_valid_r && $stable(out_data_r)))
    else $error("result overwritten while stalled");

  a_drain_col: assert property (@(posedge clk) disable iff (!rst_n)
    await_r |-> (col_r == '0))
    else $error("column count nonzero while draining");

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !div_rsp.busy)
    else $error("request taken while divider busy");

endmodule

@@ bench/tilt_shift_blur_blend_checker.sv @@
`timescale 1ns / 1ps
// Checker for tilt_shift_blur_blend_top: watches the pixel, result and register channels,
// predicts every blended pixel and compares it with what the block delivers.
// Depends on tsb_pkg for register indexes.
module tilt_shift_blur_blend_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,
  input  logic        out_tlast,
  input  logic        out_tuser,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [12:0] cfg_data,
  output int          fails,
  output int          pending
);

  localparam int LINE_DEPTH = 2048;
  localparam int HEIGHT_CAP = 4096;
  localparam int TANH_N     = 256;
  localparam longint unsigned Q30 = 64'd1073741824;

  typedef struct packed {
    logic [23:0] bgr;
    logic        row_end;
    logic        frame_end;
  } pix_t;

  pix_t        blended_q[$];
  logic [23:0] above_line[LINE_DEPTH];
  logic [23:0] middle_line[LINE_DEPTH];
  logic [23:0] win[9];
  int          col, row, drain_col;
  bit          draining;
  logic signed [31:0] weight;
  int          tanh_lut[TANH_N];
  int          cur_width, cur_height, top_row, bottom_row, softness;

  function automatic longint unsigned exp_neg(longint unsigned f);
    longint sum;
    longint unsigned term;
    sum = longint'(Q30);
    term = Q30;
    for (int i = 1; i <= 20; i++) begin
      term = ((term * f) >> 30) / i;
      if (i % 2) sum -= longint'(term);
      else sum += longint'(term);
    end
    if (sum < 0) sum = 0;
    if (sum > longint'(Q30)) sum = longint'(Q30);
    return longint'(sum);
  endfunction

  initial begin
    longint unsigned e1, a, n, rem, t, v;
    longint p;
    e1 = exp_neg(Q30);
    for (int k = 0; k < TANH_N; k++) begin
      p = 16 * k - 8 * TANH_N;
      a = (p < 0) ? -p : p;
      n = a / TANH_N;
      rem = a % TANH_N;
      t = exp_neg((rem << 30) / TANH_N);
      for (longint unsigned j = 0; j < n; j++) t = (t * e1) >> 30;
      v = ((Q30 - t) * 65536 + (Q30 + t)) / (2 * (Q30 + t));
      if (v > 32767) v = 32767;
      tanh_lut[k] = (p < 0) ? -int'(v) : int'(v);
    end
  end

  function automatic int tanh_lookup(longint diff, longint d);
    longint num, den, idx;
    num = diff * TANH_N + 4 * TANH_N * d;
    den = 8 * d;
    idx = (num <= 0) ? 0 : (2 * num + den) / (2 * den);
    if (idx > TANH_N - 1) idx = TANH_N - 1;
    return tanh_lut[idx];
  endfunction

  function automatic logic [7:0] mix(int sharp, int sum);
    longint blur, v;
    blur = (sum + 4) / 9;
    v = longint'(weight) * sharp + (65536 - longint'(weight)) * blur + 32768;
    if (v < 0) return 8'd0;
    v = v >>> 16;
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  task automatic queue_pixel(int l, int m, int r, bit re, bit fe);
    pix_t e;
    int sum;
    for (int ch = 0; ch < 3; ch++) begin
      sum = 0;
      for (int i = 0; i < 3; i++)
        sum += win[l*3+i][ch*8+:8] + win[m*3+i][ch*8+:8] + win[r*3+i][ch*8+:8];
      e.bgr[ch*8+:8] = mix(win[m*3+1][ch*8+:8], sum);
    end
    e.row_end = re;
    e.frame_end = fe;
    blended_q.push_back(e);
  endtask

  task automatic shift_column(logic [23:0] t, logic [23:0] m, logic [23:0] b, int c, int w,
                              int r, bit fe);
    longint d;
    for (int i = 0; i < 6; i++) win[i] = win[i+3];
    win[6] = t;
    win[7] = m;
    win[8] = b;
    if (c == 0) return;
    if (c == 1) begin
      d = (softness == 0) ? 1 : softness;
      weight = tanh_lookup(longint'(r) - top_row, d) - tanh_lookup(longint'(r) - bottom_row, d);
    end
    queue_pixel((c == 1) ? 2 : 0, 1, 2, 1'b0, 1'b0);
    if (c + 1 >= w) queue_pixel(1, 2, 1, 1'b1, fe);
  endtask

  task automatic take_request(logic drain, logic [23:0] px);
    int w, h, c;
    logic [23:0] a, m;
    w = (cur_width < 3) ? 3 : ((cur_width > LINE_DEPTH) ? LINE_DEPTH : cur_width);
    h = (cur_height < 3) ? 3 : ((cur_height > HEIGHT_CAP) ? HEIGHT_CAP : cur_height);
    if (drain) begin
      if (!draining) return;
      c = drain_col;
      a = above_line[c];
      m = middle_line[c];
      shift_column(a, m, a, c, w, row, 1'b1);
      if (c + 1 >= w) begin
        draining = 0;
        row = 0;
        drain_col = 0;
        col = 0;
      end else begin
        drain_col = c + 1;
      end
    end else begin
      if (draining) return;
      c = col;
      a = above_line[c];
      m = middle_line[c];
      above_line[c] = m;
      middle_line[c] = px;
      if (row >= 1) shift_column((row == 1) ? px : a, m, px, c, w, row - 1, 1'b0);
      if (c + 1 >= w) begin
        col = 0;
        if (row + 1 >= h) begin
          draining = 1;
          drain_col = 0;
        end else begin
          row++;
        end
      end else begin
        col = c + 1;
      end
    end
  endtask

  task automatic report(string what, logic [25:0] got, logic [25:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    fails++;
  endtask

  always @(posedge clk) begin
    pix_t e;
    if (!rst_n) begin
      blended_q.delete();
      for (int i = 0; i < 9; i++) win[i] = '0;
      col = 0;
      row = 0;
      drain_col = 0;
      draining = 0;
      weight = 0;
      cur_width = 640;
      cur_height = 480;
      top_row = 0;
      bottom_row = 0;
      softness = 0;
      fails = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (blended_q.size() == 0) begin
          report("unexpected", {out_tdata, out_tlast, out_tuser}, '0);
        end else begin
          e = blended_q.pop_front();
          if (out_tdata[7:0] !== e.bgr[7:0]) report("blue", out_tdata[7:0], e.bgr[7:0]);
          if (out_tdata[15:8] !== e.bgr[15:8]) report("green", out_tdata[15:8], e.bgr[15:8]);
          if (out_tdata[23:16] !== e.bgr[23:16])
            report("red", out_tdata[23:16], e.bgr[23:16]);
          if (out_tlast !== e.row_end) report("last_in_row", out_tlast, e.row_end);
          if (out_tuser !== e.frame_end) report("last_in_frame", out_tuser, e.frame_end);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          tsb_pkg::CFG_IMAGE_WIDTH:  cur_width = cfg_data[11:0];
          tsb_pkg::CFG_IMAGE_HEIGHT: cur_height = cfg_data[12:0];
          tsb_pkg::CFG_BAND_TOP:     top_row = cfg_data[11:0];
          tsb_pkg::CFG_BAND_BOTTOM:  bottom_row = cfg_data[11:0];
          tsb_pkg::CFG_DECAY:        softness = cfg_data[6:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) take_request(in_tuser, in_tdata);
    end
    pending = blended_q.size();
  end
endmodule

@@ bench/tilt_shift_blur_blend_top_tb.sv @@
`timescale 1ns / 1ps
// Testbench top for tilt_shift_blur_blend_top: drives frames, drain ticks and register
// writes with random stalls; the checker module does prediction and comparison.
module tilt_shift_blur_blend_top_tb;

  localparam int STALL_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 100;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic        in_tuser = 0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [23:0] out_tdata;
  logic        out_tlast;
  logic        out_tuser;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [12:0] cfg_data = '0;
  int          fails, pending;
  bit          stalls_on = 1;
  int          quiet_cycles;
  int          pixel_count;

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  tilt_shift_blur_blend_top dut (.*);

  tilt_shift_blur_blend_checker chk (.*);

  int sink_hold = 0;
  always @(negedge clk) begin
    if (sink_hold > 0) begin
      sink_hold--;
      out_tready <= 0;
    end else if (stalls_on && $urandom_range(0, 9) == 0) begin
      sink_hold = $urandom_range(0, 15);
      out_tready <= 0;
    end else begin
      out_tready <= 1;
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send(logic drain, logic [23:0] bgr);
    if (stalls_on && $urandom_range(0, 9) == 0) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= drain;
    in_tdata <= bgr;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    pixel_count++;
  endtask

  task automatic settle();
    in_tvalid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [12:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic setup(int w, int h, int t, int b, int d);
    settle();
    write_reg(tsb_pkg::CFG_IMAGE_WIDTH, 13'(w));
    write_reg(tsb_pkg::CFG_IMAGE_HEIGHT, 13'(h));
    write_reg(tsb_pkg::CFG_BAND_TOP, 13'(t));
    write_reg(tsb_pkg::CFG_BAND_BOTTOM, 13'(b));
    write_reg(tsb_pkg::CFG_DECAY, 13'(d));
  endtask

  function automatic logic [23:0] pick_pixel();
    case ($urandom_range(0, 5))
      0: return 24'h000000;
      1: return 24'hffffff;
      default: return 24'($urandom);
    endcase
  endfunction

  // noise: stray drains inside the frame, stray pixels before the drain row
  task automatic run_frame(int w, int h, int noise);
    for (int r = 0; r < h; r++)
      for (int c = 0; c < w; c++) begin
        if (noise > 0 && $urandom_range(0, 99) < noise) send(1'b1, 24'($urandom));
        send(1'b0, pick_pixel());
      end
    if (noise > 0 && $urandom_range(0, 99) < noise * 4) send(1'b0, 24'($urandom));
    for (int c = 0; c < w; c++) send(1'b1, 24'($urandom));
  endtask

  initial begin
    int w, h;
    repeat (3) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // narrowest frame, width below range clamps to 3
    setup(1, 3, 1, 1, 0);
    send(1'b1, 24'hffffff);
    for (int i = 0; i < 9; i++) send(1'b0, (i % 2) ? 24'hffffff : 24'h000000);
    send(1'b0, 24'h123456);
    for (int c = 0; c < 3; c++) send(1'b1, 24'h0);

    // inverted band, decay changed mid-frame
    setup(3, 3, 4095, 0, 0);
    for (int i = 0; i < 5; i++) send(1'b0, pick_pixel());
    settle();
    write_reg(tsb_pkg::CFG_DECAY, 13'd100);
    for (int i = 5; i < 9; i++) send(1'b0, pick_pixel());
    for (int c = 0; c < 3; c++) send(1'b1, 24'h0);

    pixel_count = 0;
    while (pixel_count < 1350) begin
      w = $urandom_range(3, 12);
      h = $urandom_range(3, 8);
      if ($urandom_range(0, 3) == 0)
        setup(w, h, $urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 127));
      else
        setup(w, h, $urandom_range(0, h), $urandom_range(0, h + 2), $urandom_range(0, 4));
      if (pixel_count > 1150) stalls_on = 0;
      run_frame(w, h, stalls_on ? 8 : 0);
    end
    stalls_on = 0;
    settle();
    repeat (200) @(negedge clk);
    if (fails == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

@@ files.f @@
hw/rtl/tsb_pkg.sv
hw/rtl/tsb_div.sv
hw/rtl/tilt_shift_blur_blend_top.sv
bench/tilt_shift_blur_blend_checker.sv
bench/tilt_shift_blur_blend_top_tb.sv
